@@ src/nga_pkg.sv @@
// Shared types, codes and datapath widths of the gridding accumulator.
package nga_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_SIZE     = 2'd0;
  localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_KERNEL_POINTS = 2'd2;

  // Parameter defaults.
  localparam int GRID_MAX_DEF    = 256;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int ACC_WIDTH_DEF   = 32;

  // Register reset values.
  localparam logic [8:0]  GRID_SIZE_RST     = 9'd256;
  localparam logic [13:0] KERNEL_WIDTH_RST  = 14'd768;
  localparam logic [8:0]  KERNEL_POINTS_RST = 9'd256;

  // Datapath widths, set by the field widths of the registers and inputs.
  localparam int GW   = 10;  // grid size in use
  localparam int KWW  = 14;  // kernel width
  localparam int PTW  = 9;   // table points in use
  localparam int CW   = 12;  // signed cell index
  localparam int SW   = 28;  // signed position times grid size
  localparam int WGW  = 22;  // kernel width times grid size
  localparam int DXW  = 25;  // signed offset of a cell
  localparam int D2W  = 48;  // squared distance
  localparam int SQW  = 56;  // square root operand
  localparam int RW   = 28;  // square root result
  localparam int NUMW = 37;  // dividend before the fixed shift
  localparam int QW   = 25;  // table position, Q.16
  localparam int KW   = 16;  // kernel value
  localparam int MW   = 32;  // sample part times density weight
  localparam int PW   = 19;  // rounded contribution to one cell

  // Iteration counts of the iterative units.
  localparam int SQRT_STEPS = SQW / 2;
  localparam int DIV_STEPS  = QW;

endpackage

@@ src/nufft_gridding_accumulate.sv @@
// Top level of the convolution gridding accumulator with grid and kernel table memories.
//
// Input items arrive as beats on the s_axis channel; tuser carries the operation and
// tdata the sample, cell and table fields. Results leave on m_axis, one beat for each
// read operation and none for the others. Registers are written on the cfg channel,
// which is always ready, and should only change while the block is idle.
// A table load or a cell clear is written as its input beat is taken. A cell read
// passes the states S_RD and S_OUT, where the grid entry is registered as its output
// beat. An accumulate passes the setup states S_SET1 and S_SET2, then S_COL for each
// window column and S_ROW, S_SQ, S_HIT and S_NEXT for each cell tested; each cell under
// the kernel adds 28 square root steps and 25 divider steps, two table reads, the index
// wrap (one more step for each extra wrap) and one read-modify-write of the grid memory.
// One item is worked on at a time; the next input beat is taken when the sequencer is
// back in idle, while an earlier result may still wait in the output register.
// After reset all GRID_MAX*GRID_MAX grid cells (65536 by default) are cleared one cell per
// cycle, and no input beat is taken during that pass. The kernel table is
// not cleared and must be loaded before use. When the receiver stalls, the result stays
// in the output register and a following read waits before its output beat.
module nufft_gridding_accumulate #(
  parameter int GRID_MAX    = nga_pkg::GRID_MAX_DEF,
  parameter int TABLE_DEPTH = nga_pkg::TABLE_DEPTH_DEF,
  parameter int ACC_WIDTH   = nga_pkg::ACC_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [13:0]  cfg_data_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: pos_x, pos_y, sample_re, sample_im, density_weight, cell_x, cell_y,
  // table_index, table_value
  input  logic [119:0] s_axis_tdata,
  // tuser: op
  input  logic [1:0]   s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: cell_re, cell_im
  output logic [63:0]  m_axis_tdata
);

  localparam int AW   = $clog2(GRID_MAX * GRID_MAX);
  localparam int TIW  = $clog2(TABLE_DEPTH);
  localparam int CELLS = GRID_MAX * GRID_MAX;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD, S_OUT, S_SET1, S_SET2, S_COL, S_ROW, S_SQ, S_HIT,
    S_SQRT, S_NUM, S_DIV0, S_DIV, S_TAB0, S_TAB1, S_TAB2, S_TAB3, S_FLIP,
    S_WRAP, S_PROD, S_RMW1, S_RMW2, S_NEXT
  } state_e;

  // Input fields.
  logic signed [15:0] in_pos_x, in_pos_y, in_re, in_im;
  logic [15:0]        in_dcf, in_tval;
  logic [7:0]         in_cx, in_cy, in_tidx;
  nga_pkg::op_e       in_op;

  assign in_pos_x = $signed(s_axis_tdata[15:0]);
  assign in_pos_y = $signed(s_axis_tdata[31:16]);
  assign in_re    = $signed(s_axis_tdata[47:32]);
  assign in_im    = $signed(s_axis_tdata[63:48]);
  assign in_dcf   = s_axis_tdata[79:64];
  assign in_cx    = s_axis_tdata[87:80];
  assign in_cy    = s_axis_tdata[95:88];
  assign in_tidx  = s_axis_tdata[103:96];
  assign in_tval  = s_axis_tdata[119:104];
  assign in_op    = nga_pkg::op_e'(s_axis_tuser);

  // Configuration registers.
  logic [8:0]  grid_size_q, kernel_points_q;
  logic [13:0] kernel_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q     <= nga_pkg::GRID_SIZE_RST;
      kernel_width_q  <= nga_pkg::KERNEL_WIDTH_RST;
      kernel_points_q <= nga_pkg::KERNEL_POINTS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        nga_pkg::CFG_GRID_SIZE:     grid_size_q     <= cfg_data_i[8:0];
        nga_pkg::CFG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data_i;
        nga_pkg::CFG_KERNEL_POINTS: kernel_points_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Register values saturated to their legal ranges.
  logic [nga_pkg::GW-1:0]  g_cl;
  logic [nga_pkg::KWW-1:0] w_cl;
  logic [nga_pkg::PTW-1:0] p_cl;

  always_comb begin
    if (grid_size_q < 9'd16) g_cl = nga_pkg::GW'(16);
    else if (13'(grid_size_q) > 13'(GRID_MAX)) g_cl = nga_pkg::GW'(GRID_MAX);
    else g_cl = nga_pkg::GW'(grid_size_q);
    if (kernel_width_q == 14'd0) w_cl = 14'd1;
    else if (kernel_width_q > 14'd8192) w_cl = 14'd8192;
    else w_cl = kernel_width_q;
    if (kernel_points_q < 9'd2) p_cl = 9'd2;
    else if (13'(kernel_points_q) > 13'(TABLE_DEPTH)) p_cl = nga_pkg::PTW'(TABLE_DEPTH);
    else p_cl = kernel_points_q;
  end

  // Sequencer and datapath registers.
  state_e                         state_q;
  logic [AW-1:0]                  clr_q, addr_q;
  logic                           inr_q;
  logic                           m_valid_q;
  logic [63:0]                    m_data_q;
  logic [nga_pkg::GW-1:0]         g_q;
  logic [nga_pkg::KWW-1:0]        w_q;
  logic [nga_pkg::PTW-1:0]        p_q;
  logic signed [15:0]             pos_x_q, pos_y_q, re_q, im_q;
  logic [15:0]                    dcf_q;
  logic signed [nga_pkg::SW-1:0]  sxg_q, syg_q;
  logic [nga_pkg::WGW-1:0]        wg_q;
  logic [nga_pkg::D2W-1:0]        wg2_q, dx2_q, d2_q;
  logic signed [nga_pkg::MW-1:0]  re_dcf_q, im_dcf_q;
  logic signed [nga_pkg::CW-1:0]  cx_q, cy_q, xhi_q, ylo_q, yhi_q, ix_q, iy_q;
  logic signed [nga_pkg::DXW-1:0] dx_q, dy_q;
  logic [nga_pkg::SQW-1:0]        v_q, res_q, bit_q;
  logic [4:0]                     step_q;
  logic [nga_pkg::NUMW-1:0]       num_q;
  logic [nga_pkg::WGW-1:0]        rem_q;
  logic [nga_pkg::QW-1:0]         quo_q;
  logic [TIW-1:0]                 kaddr_q, kidx_q;
  logic [32:0]                    prod0_q;
  logic [nga_pkg::KW-1:0]         kern_q;
  logic signed [nga_pkg::PW-1:0]  pr_q, pi_q;

  // Memory read data.
  logic [2*ACC_WIDTH-1:0] rdata_q;
  logic [15:0]            krd_q;

  // Window bounds and cell offsets.
  logic [nga_pkg::GW-1:0]        c_half;
  logic signed [nga_pkg::SW:0]   tx_lo, tx_hi, ty_lo, ty_hi;
  logic signed [29:0]            dx_full, dy_full;
  logic signed [nga_pkg::CW-1:0] c_s, g_s;

  assign c_half = g_q >> 1;
  assign c_s    = $signed(nga_pkg::CW'(c_half));
  assign g_s    = $signed(nga_pkg::CW'(g_q));
  assign tx_lo  = $signed({sxg_q[nga_pkg::SW-1], sxg_q}) - $signed((nga_pkg::SW+1)'(wg_q));
  assign tx_hi  = $signed({sxg_q[nga_pkg::SW-1], sxg_q}) + $signed((nga_pkg::SW+1)'(wg_q));
  assign ty_lo  = $signed({syg_q[nga_pkg::SW-1], syg_q}) - $signed((nga_pkg::SW+1)'(wg_q));
  assign ty_hi  = $signed({syg_q[nga_pkg::SW-1], syg_q}) + $signed((nga_pkg::SW+1)'(wg_q));
  assign dx_full = ($signed(30'(cx_q - c_s)) <<< 16) - $signed(30'(sxg_q));
  assign dy_full = ($signed(30'(cy_q - c_s)) <<< 16) - $signed(30'(syg_q));

  // One square root step.
  logic [nga_pkg::SQW-1:0] sq_sum;
  logic                    sq_ge;

  assign sq_sum = res_q + bit_q;
  assign sq_ge  = v_q >= sq_sum;

  // One restoring divider step.
  logic [nga_pkg::WGW:0]   div_rem2;
  logic                    div_ge;
  logic [nga_pkg::QW+23:0] div_n;

  assign div_rem2 = {rem_q, quo_q[nga_pkg::QW-1]};
  assign div_ge   = div_rem2 >= (nga_pkg::WGW+1)'(wg_q);
  assign div_n    = {num_q, 12'd0};

  // Table index of the lower interpolation point, kept off the last entry.
  logic [12:0] tab_idx;

  always_comb begin
    tab_idx = 13'(quo_q[nga_pkg::QW-1:16]);
    if (tab_idx + 13'd1 >= 13'(TABLE_DEPTH)) tab_idx = 13'(TABLE_DEPTH - 2);
  end

  // Kernel interpolation sum.
  logic [33:0] ksum;

  assign ksum = 34'(prod0_q) + 34'(krd_q) * 34'(quo_q[15:0]) + 34'd32768;

  // Mirror flips on the unwrapped indices.
  logic signed [nga_pkg::CW-1:0] fx, fy;

  always_comb begin
    fx = cx_q;
    fy = cy_q;
    if (cx_q < 0) begin
      fx = fx + g_s;
      fy = g_s - fy;
    end
    if (cx_q >= g_s) begin
      fx = fx - g_s;
      fy = g_s - fy;
    end
    if (cy_q < 0) begin
      fy = fy + g_s;
      fx = g_s - fx;
    end
    if (cy_q >= g_s) begin
      fy = fy - g_s;
      fx = g_s - fx;
    end
  end

  logic ix_ok, iy_ok;

  assign ix_ok = (ix_q >= 0) && (ix_q < g_s);
  assign iy_ok = (iy_q >= 0) && (iy_q < g_s);

  // Rounded contributions of the sample to a cell.
  logic signed [48:0] pr_full, pi_full;

  assign pr_full = 49'(re_dcf_q) * $signed({1'b0, kern_q}) + (49'sd1 <<< 29);
  assign pi_full = 49'(im_dcf_q) * $signed({1'b0, kern_q}) + (49'sd1 <<< 29);

  // Saturating cell update.
  logic signed [ACC_WIDTH-1:0] acc_re, acc_im, new_re, new_im;

  assign acc_re = $signed(rdata_q[ACC_WIDTH-1:0]);
  assign acc_im = $signed(rdata_q[2*ACC_WIDTH-1:ACC_WIDTH]);

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [nga_pkg::PW-1:0] b
  );
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      sat_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sat_add = s[ACC_WIDTH-1:0];
    end
  endfunction

  assign new_re = sat_add(acc_re, pr_q);
  assign new_im = sat_add(acc_im, pi_q);

  // Saturation of an accumulator to the 32-bit output.
  function automatic logic [31:0] out32(input logic signed [ACC_WIDTH-1:0] a);
    logic signed [63:0] v;
    v = 64'(a);
    if (v > 64'sd2147483647) out32 = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) out32 = 32'h8000_0000;
    else out32 = v[31:0];
  endfunction

  // Grid address of a column and row.
  function automatic logic [AW-1:0] cell_addr(
    input logic [nga_pkg::CW-1:0] x,
    input logic [nga_pkg::CW-1:0] y
  );
    cell_addr = AW'(x) * AW'(GRID_MAX) + AW'(y);
  endfunction

  logic in_acc, cell_in_range;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cell_in_range = (nga_pkg::GW'(in_cx) < g_cl) && (nga_pkg::GW'(in_cy) < g_cl);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      clr_q     <= '0;
      addr_q    <= '0;
      inr_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      g_q       <= '0;
      w_q       <= '0;
      p_q       <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      re_q      <= '0;
      im_q      <= '0;
      dcf_q     <= '0;
      sxg_q     <= '0;
      syg_q     <= '0;
      wg_q      <= '0;
      wg2_q     <= '0;
      dx2_q     <= '0;
      d2_q      <= '0;
      re_dcf_q  <= '0;
      im_dcf_q  <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      xhi_q     <= '0;
      ylo_q     <= '0;
      yhi_q     <= '0;
      ix_q      <= '0;
      iy_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      v_q       <= '0;
      res_q     <= '0;
      bit_q     <= '0;
      step_q    <= '0;
      num_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      kaddr_q   <= '0;
      kidx_q    <= '0;
      prod0_q   <= '0;
      kern_q    <= '0;
      pr_q      <= '0;
      pi_q      <= '0;
    end else begin
      // A taken result is dropped unless the read stage refills the register.
      if (m_valid_q && m_axis_tready && state_q != S_OUT) m_valid_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              nga_pkg::OP_ACCUM: begin
                g_q     <= g_cl;
                w_q     <= w_cl;
                p_q     <= p_cl;
                pos_x_q <= in_pos_x;
                pos_y_q <= in_pos_y;
                re_q    <= in_re;
                im_q    <= in_im;
                dcf_q   <= in_dcf;
                state_q <= S_SET1;
              end
              nga_pkg::OP_READ: begin
                addr_q  <= cell_addr(nga_pkg::CW'(in_cx), nga_pkg::CW'(in_cy));
                inr_q   <= cell_in_range;
                state_q <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: state_q <= S_OUT;
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= inr_q ? {out32(acc_im), out32(acc_re)} : 64'd0;
            state_q   <= S_IDLE;
          end
        end
        // Scaled position and kernel radius in grid units of 1/65536.
        S_SET1: begin
          sxg_q   <= nga_pkg::SW'(pos_x_q * $signed({1'b0, g_q, 1'b0}));
          syg_q   <= nga_pkg::SW'(pos_y_q * $signed({1'b0, g_q, 1'b0}));
          wg_q    <= nga_pkg::WGW'(w_q * g_q);
          state_q <= S_SET2;
        end
        // Window bounds, squared radius and weighted sample.
        S_SET2: begin
          cx_q     <= nga_pkg::CW'(tx_lo >>> 16) + c_s;
          xhi_q    <= nga_pkg::CW'(tx_hi >>> 16) + c_s + nga_pkg::CW'(1);
          ylo_q    <= nga_pkg::CW'(ty_lo >>> 16) + c_s;
          yhi_q    <= nga_pkg::CW'(ty_hi >>> 16) + c_s + nga_pkg::CW'(1);
          wg2_q    <= nga_pkg::D2W'(wg_q * wg_q);
          re_dcf_q <= nga_pkg::MW'(re_q * $signed({1'b0, dcf_q}));
          im_dcf_q <= nga_pkg::MW'(im_q * $signed({1'b0, dcf_q}));
          state_q  <= S_COL;
        end
        S_COL: begin
          dx_q    <= nga_pkg::DXW'(dx_full);
          cy_q    <= ylo_q;
          state_q <= S_ROW;
        end
        S_ROW: begin
          dy_q    <= nga_pkg::DXW'(dy_full);
          dx2_q   <= nga_pkg::D2W'(dx_q * dx_q);
          state_q <= S_SQ;
        end
        S_SQ: begin
          d2_q    <= dx2_q + nga_pkg::D2W'(dy_q * dy_q);
          state_q <= S_HIT;
        end
        // Cells outside the kernel radius are skipped.
        S_HIT: begin
          if (d2_q < wg2_q) begin
            v_q     <= {d2_q, 8'd0};
            res_q   <= '0;
            bit_q   <= nga_pkg::SQW'(1) << (nga_pkg::SQW - 2);
            step_q  <= '0;
            state_q <= S_SQRT;
          end else begin
            state_q <= S_NEXT;
          end
        end
        // Bitwise integer square root, two operand bits a step.
        S_SQRT: begin
          if (sq_ge) begin
            v_q   <= v_q - sq_sum;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          step_q <= step_q + 5'd1;
          if (step_q == 5'(nga_pkg::SQRT_STEPS - 1)) state_q <= S_NUM;
        end
        S_NUM: begin
          num_q   <= nga_pkg::NUMW'(res_q[nga_pkg::RW-1:0] * (p_q - nga_pkg::PTW'(1)));
          state_q <= S_DIV0;
        end
        // The quotient fits in QW bits, so the upper dividend bits start as remainder.
        S_DIV0: begin
          rem_q   <= div_n[nga_pkg::QW+nga_pkg::WGW-1:nga_pkg::QW];
          quo_q   <= div_n[nga_pkg::QW-1:0];
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= div_ge ? nga_pkg::WGW'(div_rem2 - (nga_pkg::WGW+1)'(wg_q))
                           : div_rem2[nga_pkg::WGW-1:0];
          quo_q  <= {quo_q[nga_pkg::QW-2:0], div_ge};
          step_q <= step_q + 5'd1;
          if (step_q == 5'(nga_pkg::DIV_STEPS - 1)) state_q <= S_TAB0;
        end
        // Two table reads and linear interpolation.
        S_TAB0: begin
          kidx_q  <= tab_idx[TIW-1:0];
          kaddr_q <= tab_idx[TIW-1:0];
          state_q <= S_TAB1;
        end
        S_TAB1: begin
          kaddr_q <= kidx_q + TIW'(1);
          state_q <= S_TAB2;
        end
        S_TAB2: begin
          prod0_q <= 33'(krd_q) * (33'h1_0000 - 33'(quo_q[15:0]));
          state_q <= S_TAB3;
        end
        S_TAB3: begin
          kern_q  <= ksum[31:16];
          state_q <= S_FLIP;
        end
        S_FLIP: begin
          ix_q    <= fx;
          iy_q    <= fy;
          state_q <= S_WRAP;
        end
        // Remaining indices are brought into range one grid size a step.
        S_WRAP: begin
          if (ix_q < 0) ix_q <= ix_q + g_s;
          else if (ix_q >= g_s) ix_q <= ix_q - g_s;
          if (iy_q < 0) iy_q <= iy_q + g_s;
          else if (iy_q >= g_s) iy_q <= iy_q - g_s;
          if (ix_ok && iy_ok) state_q <= S_PROD;
        end
        S_PROD: begin
          pr_q    <= pr_full[48:30];
          pi_q    <= pi_full[48:30];
          addr_q  <= cell_addr(ix_q, iy_q);
          state_q <= S_RMW1;
        end
        S_RMW1: state_q <= S_RMW2;
        S_RMW2: state_q <= S_NEXT;
        S_NEXT: begin
          if (cy_q < yhi_q) begin
            cy_q    <= cy_q + nga_pkg::CW'(1);
            state_q <= S_ROW;
          end else if (cx_q < xhi_q) begin
            cx_q    <= cx_q + nga_pkg::CW'(1);
            state_q <= S_COL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Grid memory write port: clearing pass, clear operation, or cell update.
  logic                   g_we;
  logic [AW-1:0]          g_waddr;
  logic [2*ACC_WIDTH-1:0] g_wdata;

  always_comb begin
    g_we    = 1'b0;
    g_waddr = addr_q;
    g_wdata = '0;
    if (state_q == S_INIT) begin
      g_we    = 1'b1;
      g_waddr = clr_q;
    end else if (in_acc && in_op == nga_pkg::OP_CLEAR && cell_in_range) begin
      g_we    = 1'b1;
      g_waddr = cell_addr(nga_pkg::CW'(in_cx), nga_pkg::CW'(in_cy));
    end else if (state_q == S_RMW2) begin
      g_we    = 1'b1;
      g_wdata = {new_im, new_re};
    end
  end

  logic [2*ACC_WIDTH-1:0] grid_mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_waddr] <= g_wdata;
    rdata_q <= grid_mem[addr_q];
  end

  // Kernel table memory.
  logic k_we;

  assign k_we = in_acc && in_op == nga_pkg::OP_LOAD && (13'(in_tidx) < 13'(TABLE_DEPTH));

  logic [15:0] kern_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (k_we) kern_mem[TIW'(in_tidx)] <= in_tval;
    krd_q <= kern_mem[kaddr_q];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The cell update writes back the entry that was read at the same address in S_RMW1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RMW2 |-> $past(state_q) == S_RMW1 && $stable(addr_q))
    else $error("grid update address changed between read and write");

  // The lower interpolation point always has a following table entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAB1 |-> 13'(kaddr_q) <= 13'(TABLE_DEPTH - 2))
    else $error("kernel table index past the last pair");

  // Wrapped indices lie on the grid when the update address is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROD |-> ix_ok && iy_ok)
    else $error("wrapped cell index outside the grid");

  // A result appears only at the end of a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output beat without a read");

endmodule
